[rtl/aspe_pkg.sv]
// Package: shared constants, types and character codes for the expression evaluator.
package aspe_pkg;

    // Stack depths and counter widths
    localparam int VALUE_DEPTH = 64;
    localparam int OP_DEPTH    = 128;
    localparam int VCNT_W      = $clog2(VALUE_DEPTH + 1);
    localparam int OCNT_W      = $clog2(OP_DEPTH + 1);
    localparam logic [VCNT_W-1:0] VAL_FULL = VCNT_W'(VALUE_DEPTH);
    localparam logic [OCNT_W-1:0] OP_FULL  = OCNT_W'(OP_DEPTH);

    // Payload widths
    localparam int CHAR_W   = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
    localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;

    // Operator stack entry
    typedef enum logic [1:0] {
        OPC_PAREN = 2'd0,
        OPC_PLUS  = 2'd1,
        OPC_MINUS = 2'd2
    } opc_t;

    // Result status
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    // Value stack shift command
    typedef enum logic [1:0] {
        V_HOLD,
        V_PUSH,
        V_POP,
        V_REPLACE
    } val_cmd_t;

    // Operator stack shift command
    typedef enum logic [2:0] {
        O_HOLD,
        O_PUSH,
        O_POP,
        O_POP2,
        O_REPLACE
    } op_cmd_t;

    typedef struct packed {
        val_cmd_t           cmd;
        logic [VALUE_W-1:0] wdata;
    } val_ctl_t;

    typedef struct packed {
        op_cmd_t cmd;
        opc_t    code;
    } op_ctl_t;

endpackage

[rtl/aspe_if.sv]
// Interfaces: character input channel and result output channel.
interface aspe_in_if;
    logic                         valid;
    logic                         ready;
    logic [aspe_pkg::CHAR_W-1:0]  char_code;
    logic                         last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface aspe_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [aspe_pkg::VALUE_W-1:0] value;
    logic [aspe_pkg::STATUS_W-1:0]       status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

[rtl/aspe_val_cell.sv]
// Value stack cell: one 32-bit entry that shifts with its neighbors on push and pop.
module aspe_val_cell (
    input  logic                            clk,
    input  aspe_pkg::val_ctl_t              ctl,
    input  logic                            head,
    input  logic [aspe_pkg::VALUE_W-1:0]    from_above,
    input  logic [aspe_pkg::VALUE_W-1:0]    from_below,
    output logic [aspe_pkg::VALUE_W-1:0]    data
);

    logic [aspe_pkg::VALUE_W-1:0] data_reg;
    logic [aspe_pkg::VALUE_W-1:0] data_next;

    // Select the entry's next content
    always_comb
    begin
        unique case (ctl.cmd)
            aspe_pkg::V_PUSH:    data_next = head ? ctl.wdata : from_above;
            aspe_pkg::V_POP:     data_next = from_below;
            aspe_pkg::V_REPLACE: data_next = head ? ctl.wdata : data_reg;
            default:             data_next = data_reg;
        endcase
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[rtl/aspe_op_cell.sv]
// Operator stack cell: one operator code that shifts by one or two places on pop.
module aspe_op_cell (
    input  logic               clk,
    input  aspe_pkg::op_ctl_t  ctl,
    input  logic               head,
    input  aspe_pkg::opc_t     from_above,
    input  aspe_pkg::opc_t     from_below,
    input  aspe_pkg::opc_t     from_below2,
    output aspe_pkg::opc_t     data
);

    aspe_pkg::opc_t data_reg;
    aspe_pkg::opc_t data_next;

    // Select the entry's next content
    always_comb
    begin
        unique case (ctl.cmd)
            aspe_pkg::O_PUSH:    data_next = head ? ctl.code : from_above;
            aspe_pkg::O_POP:     data_next = from_below;
            aspe_pkg::O_POP2:    data_next = from_below2;
            aspe_pkg::O_REPLACE: data_next = head ? ctl.code : data_reg;
            default:             data_next = data_reg;
        endcase
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[rtl/add_sub_paren_expression_evaluator.sv]
// Top level: streaming evaluator of plus/minus/parenthesis expressions.
//
// Usage: characters enter on in_chan one per transaction (char_code, last).
// Digits, '+', '-', '(' and ')' act; every other code is ignored like a
// space. The transaction with last set closes the expression: one result
// (value, status) leaves on out_chan, and the evaluator starts the next
// expression clean. Status 0 is ok, 1 stack overflow, 2 malformed
// (underflow); value reads 0 when status is nonzero.
// Throughput: one character per cycle. Each character is settled in the
// cycle it is accepted: the value and operator stacks are rows of shift
// cells whose top sits next to the fold adder, so no memory port
// limits the rate. A closing transaction does not stall in_chan while the
// output register is free. The accepted last character sets finish_reg,
// and the result is then registered on out_chan once that slot is free.
// Stall: a finished result waits in the output register; input keeps
// flowing until a second result must be stored while the first is still
// held, and then in_chan.ready drops until out_chan takes the first one.
// Reset: clears counts, accumulator, error and the output valid flag; the
// stack cells need no clearing since only entries below a count are read.
module add_sub_paren_expression_evaluator (
    input  logic        clk,
    input  logic        rst_n,
    aspe_in_if.sink     in_chan,
    aspe_out_if.source  out_chan
);

    localparam int VW = aspe_pkg::VALUE_W;
    localparam int CW = aspe_pkg::VCNT_W;
    localparam int OW = aspe_pkg::OCNT_W;

    // Control state
    logic [CW-1:0]          vcnt_reg, vcnt_next;
    logic [OW-1:0]          ocnt_reg, ocnt_next;
    logic [VW-1:0]          accum_reg, accum_next;
    logic                   present_reg, present_next;
    aspe_pkg::status_t      err_reg, err_next;
    logic                   finish_reg, finish_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VW-1:0]          value_reg, value_next;
    aspe_pkg::status_t      status_reg, status_next;

    // Stack rows
    logic [VW-1:0]          vdata [aspe_pkg::VALUE_DEPTH];
    aspe_pkg::opc_t         odata [aspe_pkg::OP_DEPTH];
    aspe_pkg::val_ctl_t     vctl;
    aspe_pkg::op_ctl_t      octl;

    logic                   accept;
    logic                   slot_free;
    logic                   fire;
    logic                   upd;

    // Effective state: cleared while a finished expression is being closed
    logic [CW-1:0]          e_vcnt;
    logic [OW-1:0]          e_ocnt;
    logic [VW-1:0]          e_accum;
    logic                   e_present;
    aspe_pkg::status_t      e_err;

    logic [VW-1:0]          cur;
    logic                   fold_en;
    logic                   vpop_ok;
    logic [VW-1:0]          vtop;
    logic [VW-1:0]          fold_x;
    logic [VW-1:0]          x;
    aspe_pkg::status_t      err_char;
    logic [VW-1:0]          digit;
    logic [aspe_pkg::CHAR_W-1:0] ch;

    // Closing fold on the registered state
    logic [VW-1:0]          f_cur;
    logic                   f_fold;
    logic [VW-1:0]          f_v;
    logic [VW-1:0]          f_x;
    aspe_pkg::status_t      f_st;

    // Handshake
    assign slot_free     = !out_valid_reg || out_chan.ready;
    assign fire          = finish_reg && slot_free;
    assign in_chan.ready = !finish_reg || slot_free;
    assign accept        = in_chan.valid && in_chan.ready;
    assign upd           = !finish_reg || fire;
    assign ch            = in_chan.char_code;

    assign e_vcnt    = finish_reg ? '0 : vcnt_reg;
    assign e_ocnt    = finish_reg ? '0 : ocnt_reg;
    assign e_accum   = finish_reg ? '0 : accum_reg;
    assign e_present = finish_reg ? 1'b0 : present_reg;
    assign e_err     = finish_reg ? aspe_pkg::ST_OK : err_reg;

    // Fold the pending operator with the current number
    assign cur     = e_present ? e_accum : '0;
    assign vpop_ok = (e_vcnt != '0);
    assign vtop    = vpop_ok ? vdata[0] : '0;
    assign fold_en = (e_ocnt != '0) &&
                     ((odata[0] == aspe_pkg::OPC_PLUS) || (odata[0] == aspe_pkg::OPC_MINUS));
    assign fold_x  = (odata[0] == aspe_pkg::OPC_PLUS) ? (vtop + cur) : (vtop - cur);
    assign x       = fold_en ? fold_x : cur;
    assign digit   = VW'(ch[3:0]);

    // Decode the character into stack commands and next state
    always_comb
    begin
        vctl.cmd     = aspe_pkg::V_HOLD;
        vctl.wdata   = x;
        octl.cmd     = aspe_pkg::O_HOLD;
        octl.code    = aspe_pkg::OPC_PAREN;
        vcnt_next    = e_vcnt;
        ocnt_next    = e_ocnt;
        accum_next   = e_accum;
        present_next = e_present;
        err_char     = aspe_pkg::ST_OK;

        if (accept)
        begin
            priority if ((ch >= aspe_pkg::CH_ZERO) && (ch <= aspe_pkg::CH_NINE))
            begin
                accum_next   = (e_accum << 3) + (e_accum << 1) + digit;
                present_next = 1'b1;
            end
            else if (ch == aspe_pkg::CH_OPEN)
            begin
                if (e_present)
                begin
                    if (e_vcnt != aspe_pkg::VAL_FULL)
                    begin
                        vctl.cmd   = aspe_pkg::V_PUSH;
                        vctl.wdata = e_accum;
                        vcnt_next  = e_vcnt + CW'(1);
                    end
                    else
                    begin
                        err_char = aspe_pkg::ST_OVERFLOW;
                    end
                end
                if (e_ocnt != aspe_pkg::OP_FULL)
                begin
                    octl.cmd  = aspe_pkg::O_PUSH;
                    ocnt_next = e_ocnt + OW'(1);
                end
                else
                begin
                    err_char = aspe_pkg::ST_OVERFLOW;
                end
            end
            else if (ch == aspe_pkg::CH_CLOSE)
            begin
                if (fold_en)
                begin
                    if (vpop_ok)
                    begin
                        vctl.cmd  = aspe_pkg::V_POP;
                        vcnt_next = e_vcnt - CW'(1);
                    end
                    else
                    begin
                        err_char = aspe_pkg::ST_UNDERFLOW;
                    end
                    if (e_ocnt >= OW'(2))
                    begin
                        octl.cmd  = aspe_pkg::O_POP2;
                        ocnt_next = e_ocnt - OW'(2);
                    end
                    else
                    begin
                        octl.cmd  = aspe_pkg::O_POP;
                        ocnt_next = '0;
                        err_char  = aspe_pkg::ST_UNDERFLOW;
                    end
                end
                else if (e_ocnt != '0)
                begin
                    octl.cmd  = aspe_pkg::O_POP;
                    ocnt_next = e_ocnt - OW'(1);
                end
                else
                begin
                    err_char = aspe_pkg::ST_UNDERFLOW;
                end
                accum_next   = x;
                present_next = 1'b1;
            end
            else if ((ch == aspe_pkg::CH_PLUS) || (ch == aspe_pkg::CH_MINUS))
            begin
                octl.code = (ch == aspe_pkg::CH_PLUS) ? aspe_pkg::OPC_PLUS
                                                      : aspe_pkg::OPC_MINUS;
                if (fold_en)
                begin
                    octl.cmd = aspe_pkg::O_REPLACE;
                    if (vpop_ok)
                    begin
                        vctl.cmd = aspe_pkg::V_REPLACE;
                    end
                    else
                    begin
                        vctl.cmd  = aspe_pkg::V_PUSH;
                        vcnt_next = CW'(1);
                        err_char  = aspe_pkg::ST_UNDERFLOW;
                    end
                end
                else
                begin
                    if (e_vcnt != aspe_pkg::VAL_FULL)
                    begin
                        vctl.cmd  = aspe_pkg::V_PUSH;
                        vcnt_next = e_vcnt + CW'(1);
                    end
                    else
                    begin
                        err_char = aspe_pkg::ST_OVERFLOW;
                    end
                    if (e_ocnt != aspe_pkg::OP_FULL)
                    begin
                        octl.cmd  = aspe_pkg::O_PUSH;
                        ocnt_next = e_ocnt + OW'(1);
                    end
                    else
                    begin
                        err_char = aspe_pkg::ST_OVERFLOW;
                    end
                end
                accum_next   = '0;
                present_next = 1'b0;
            end
            else
            begin
                accum_next = e_accum;
            end
        end
    end

    // Keep the first error of the expression
    assign err_next    = (e_err != aspe_pkg::ST_OK) ? e_err : err_char;
    assign finish_next = upd ? (accept && in_chan.last) : finish_reg;

    // Closing implied plus on the finished expression
    assign f_cur  = present_reg ? accum_reg : '0;
    assign f_fold = (ocnt_reg != '0) &&
                    ((odata[0] == aspe_pkg::OPC_PLUS) || (odata[0] == aspe_pkg::OPC_MINUS));
    assign f_v    = (vcnt_reg != '0) ? vdata[0] : '0;
    assign f_x    = !f_fold ? f_cur
                  : ((odata[0] == aspe_pkg::OPC_PLUS) ? (f_v + f_cur) : (f_v - f_cur));

    always_comb
    begin
        f_st = err_reg;
        if (err_reg == aspe_pkg::ST_OK)
        begin
            if (f_fold && (vcnt_reg == '0))
            begin
                f_st = aspe_pkg::ST_UNDERFLOW;
            end
            else if (!f_fold && ((vcnt_reg == aspe_pkg::VAL_FULL) ||
                                 (ocnt_reg == aspe_pkg::OP_FULL)))
            begin
                f_st = aspe_pkg::ST_OVERFLOW;
            end
        end
    end

    // Output register next values
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_chan.ready;
        value_next     = value_reg;
        status_next    = status_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
            value_next     = (f_st == aspe_pkg::ST_OK) ? f_x : '0;
            status_next    = f_st;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcnt_reg      <= '0;
            ocnt_reg      <= '0;
            accum_reg     <= '0;
            present_reg   <= 1'b0;
            err_reg       <= aspe_pkg::ST_OK;
            finish_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (upd)
            begin
                vcnt_reg    <= vcnt_next;
                ocnt_reg    <= ocnt_next;
                accum_reg   <= accum_next;
                present_reg <= present_next;
                err_reg     <= err_next;
            end
            finish_reg    <= finish_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    assign out_chan.valid  = out_valid_reg;
    assign out_chan.value  = value_reg;
    assign out_chan.status = status_reg;

    // Value stack row
    for (genvar i = 0; i < aspe_pkg::VALUE_DEPTH; i++)
    begin : g_val
        logic [VW-1:0] above;
        logic [VW-1:0] below;
        if (i == 0)
        begin : g_head
            assign above = '0;
        end
        else
        begin : g_body
            assign above = vdata[i-1];
        end
        if (i == aspe_pkg::VALUE_DEPTH - 1)
        begin : g_tail
            assign below = '0;
        end
        else
        begin : g_mid
            assign below = vdata[i+1];
        end
        aspe_val_cell u_cell (
            .clk        (clk),
            .ctl        (vctl),
            .head       (i == 0),
            .from_above (above),
            .from_below (below),
            .data       (vdata[i])
        );
    end

    // Operator stack row
    for (genvar j = 0; j < aspe_pkg::OP_DEPTH; j++)
    begin : g_op
        aspe_pkg::opc_t above;
        aspe_pkg::opc_t below;
        aspe_pkg::opc_t below2;
        if (j == 0)
        begin : g_head
            assign above = aspe_pkg::OPC_PAREN;
        end
        else
        begin : g_body
            assign above = odata[j-1];
        end
        if (j + 1 < aspe_pkg::OP_DEPTH)
        begin : g_b1
            assign below = odata[j+1];
        end
        else
        begin : g_b1_end
            assign below = aspe_pkg::OPC_PAREN;
        end
        if (j + 2 < aspe_pkg::OP_DEPTH)
        begin : g_b2
            assign below2 = odata[j+2];
        end
        else
        begin : g_b2_end
            assign below2 = aspe_pkg::OPC_PAREN;
        end
        aspe_op_cell u_cell (
            .clk         (clk),
            .ctl         (octl),
            .head        (j == 0),
            .from_above  (above),
            .from_below  (below),
            .from_below2 (below2),
            .data        (odata[j])
        );
    end

endmodule

[verif/add_sub_paren_expression_evaluator_tb.sv]
// Testbench: drives character streams into the expression evaluator and checks each result.
module add_sub_paren_expression_evaluator_tb;

    import aspe_pkg::*;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        status_t            status;
    } eval_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic rx_blocked = 1'b0;
    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    event hold_off_trig;

    // Predicted evaluator state
    logic [VALUE_W-1:0] stk_vals [VALUE_DEPTH];
    int                 n_vals;
    opc_t               stk_ops [OP_DEPTH];
    int                 n_ops;
    logic [VALUE_W-1:0] num_acc;
    bit                 num_seen;
    status_t            err_code;

    eval_result_t pending_results [$];
    logic [CHAR_W-1:0] expr_buf [$];

    aspe_in_if  in_if ();
    aspe_out_if out_if ();

    add_sub_paren_expression_evaluator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_if),
        .out_chan (out_if)
    );

    // Toggle the clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Hold the output channel off for a long stretch when triggered
    always
    begin
        @(hold_off_trig);
        rx_blocked <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_blocked <= 1'b0;
    end

    // Check accepted results and drive output ready
    always @(posedge clk)
    begin
        if (out_if.valid && out_if.ready)
            check_result(out_if.value, out_if.status);
        out_if.ready <= !rx_blocked && ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // ---------------- prediction ----------------

    function automatic void clear_state();
        n_vals   = 0;
        n_ops    = 0;
        num_acc  = '0;
        num_seen = 1'b0;
        err_code = ST_OK;
    endfunction

    function automatic void note_error(input status_t code);
        if (err_code == ST_OK)
            err_code = code;
    endfunction

    function automatic void push_value(input logic [VALUE_W-1:0] v);
        if (n_vals < VALUE_DEPTH)
        begin
            stk_vals[n_vals] = v;
            n_vals++;
        end
        else
            note_error(ST_OVERFLOW);
    endfunction

    function automatic logic [VALUE_W-1:0] pop_value();
        if (n_vals == 0)
        begin
            note_error(ST_UNDERFLOW);
            return '0;
        end
        n_vals--;
        return stk_vals[n_vals];
    endfunction

    function automatic void push_opcode(input opc_t op);
        if (n_ops < OP_DEPTH)
        begin
            stk_ops[n_ops] = op;
            n_ops++;
        end
        else
            note_error(ST_OVERFLOW);
    endfunction

    function automatic logic [VALUE_W-1:0] current_number();
        return num_seen ? num_acc : '0;
    endfunction

    // Fold a pending plus or minus on the operator top with x
    function automatic logic [VALUE_W-1:0] fold_pending(input logic [VALUE_W-1:0] x);
        opc_t               top;
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] r;
        r = x;
        if (n_ops > 0)
        begin
            top = stk_ops[n_ops-1];
            if (top == OPC_PLUS || top == OPC_MINUS)
            begin
                n_ops--;
                v = pop_value();
                r = (top == OPC_PLUS) ? v + x : v - x;
            end
        end
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] apply_operator(input opc_t op);
        logic [VALUE_W-1:0] x;
        x = fold_pending(current_number());
        push_value(x);
        push_opcode(op);
        num_acc  = '0;
        num_seen = 1'b0;
        return x;
    endfunction

    // Advance the predicted state by one character, queue a result on last
    function automatic void predict_char(input logic [CHAR_W-1:0] c, input bit lst);
        logic [VALUE_W-1:0] x;
        eval_result_t       res;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            num_acc  = num_acc * 32'd10 + (32'(c) - 32'(CH_ZERO));
            num_seen = 1'b1;
        end
        else if (c == CH_OPEN)
        begin
            // a number before the paren is stacked but stays in the accumulator
            if (num_seen)
                push_value(num_acc);
            push_opcode(OPC_PAREN);
        end
        else if (c == CH_CLOSE)
        begin
            x = fold_pending(current_number());
            if (n_ops == 0)
                note_error(ST_UNDERFLOW);
            else
                n_ops--;
            num_acc  = x;
            num_seen = 1'b1;
        end
        else if (c == CH_PLUS)
            void'(apply_operator(OPC_PLUS));
        else if (c == CH_MINUS)
            void'(apply_operator(OPC_MINUS));

        if (lst)
        begin
            x = apply_operator(OPC_PLUS);
            res.status = err_code;
            res.value  = (err_code == ST_OK) ? x : '0;
            pending_results.push_back(res);
            clear_state();
        end
    endfunction

    // ---------------- checking ----------------

    task automatic check_result(input logic [VALUE_W-1:0] v, input logic [STATUS_W-1:0] s);
        eval_result_t want;
        if (pending_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("unexpected result: value=%0d status=%0d", $signed(v), s);
            return;
        end
        want = pending_results.pop_front();
        if (v !== want.value || s !== want.status)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("result mismatch: value exp=%0d got=%0d, status exp=%0d got=%0d",
                         $signed(want.value), $signed(v), want.status, s);
        end
    endtask

    // ---------------- stimulus ----------------

    // Offer one character and hold it until the transaction completes
    task automatic send_char(input logic [CHAR_W-1:0] c, input bit lst);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid     <= 1'b1;
        in_if.char_code <= c;
        in_if.last      <= lst;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        predict_char(c, lst);
    endtask

    task automatic send_expr();
        for (int i = 0; i < expr_buf.size(); i++)
            send_char(expr_buf[i], i == expr_buf.size() - 1);
    endtask

    function automatic logic [CHAR_W-1:0] rand_digit();
        return CH_ZERO + CHAR_W'($urandom_range(0, 9));
    endfunction

    function automatic void add_noise();
        if ($urandom_range(0, 7) == 0)
            expr_buf.push_back(CH_SPACE);
        else if ($urandom_range(0, 39) == 0)
            expr_buf.push_back(CH_UPPER_A + CHAR_W'($urandom_range(0, 25)));
    endfunction

    // Mostly short numbers, now and then long enough to wrap
    function automatic void add_number();
        int ndig;
        ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 10) : $urandom_range(1, 3);
        repeat (ndig) expr_buf.push_back(rand_digit());
    endfunction

    // Append a well-formed expression with random content
    function automatic void add_expr(input int depth);
        int nterms;
        nterms = $urandom_range(1, 4);
        if ($urandom_range(0, 3) == 0)
            expr_buf.push_back(CH_MINUS);
        for (int i = 0; i < nterms; i++)
        begin
            if (i > 0)
                expr_buf.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            add_noise();
            if (depth > 0 && $urandom_range(0, 2) == 0)
            begin
                expr_buf.push_back(CH_OPEN);
                add_expr(depth - 1);
                expr_buf.push_back(CH_CLOSE);
            end
            else
                add_number();
            add_noise();
        end
    endfunction

    // Append a short run of arbitrary characters
    function automatic void add_garbage();
        int len;
        len = $urandom_range(1, 12);
        repeat (len)
        begin
            case ($urandom_range(0, 7))
                0, 1, 2: expr_buf.push_back(rand_digit());
                3:       expr_buf.push_back(CH_PLUS);
                4:       expr_buf.push_back(CH_MINUS);
                5:       expr_buf.push_back(CH_OPEN);
                6:       expr_buf.push_back(CH_CLOSE);
                default: expr_buf.push_back(CHAR_W'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    // ---------------- tests ----------------

    task automatic test_directed_cases();
        // ignored codes at both ends of the range, then a lone digit
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(CH_SPACE, 1'b0);
        send_char(CH_UPPER_A, 1'b0);
        send_char(8'h37, 1'b1);
        // leading minus negates a parenthesized difference
        send_char(CH_MINUS, 1'b0);
        send_char(CH_OPEN, 1'b0);
        send_char(8'h33, 1'b0);
        send_char(CH_MINUS, 1'b0);
        send_char(8'h39, 1'b0);
        send_char(CH_CLOSE, 1'b1);
        // number before an open paren stays in the accumulator
        send_char(8'h32, 1'b0);
        send_char(CH_OPEN, 1'b0);
        send_char(8'h31, 1'b0);
        send_char(CH_CLOSE, 1'b0);
        send_char(CH_PLUS, 1'b0);
        send_char(CH_ZERO, 1'b1);
        // close paren with nothing open is malformed
        send_char(CH_CLOSE, 1'b1);
        // unclosed open paren is ignored
        send_char(CH_OPEN, 1'b1);
        // trailing operator, then two underflows keeping the first code
        send_char(8'h34, 1'b0);
        send_char(CH_PLUS, 1'b1);
        send_char(CH_CLOSE, 1'b0);
        send_char(CH_CLOSE, 1'b1);
    endtask

    // Fill each stack to just below and just past its depth
    task automatic test_stack_limits();
        for (int n = VALUE_DEPTH - 1; n <= VALUE_DEPTH; n++)
        begin
            repeat (n)
            begin
                send_char(rand_digit(), 1'b0);
                send_char(CH_OPEN, 1'b0);
            end
            send_char(rand_digit(), 1'b1);
        end
        for (int n = OP_DEPTH - 1; n <= OP_DEPTH; n++)
        begin
            repeat (n - 1) send_char(CH_OPEN, 1'b0);
            send_char(CH_OPEN, 1'b1);
        end
    endtask

    task automatic test_random_expressions(input int n_chars);
        int sent;
        sent = 0;
        while (sent < n_chars)
        begin
            expr_buf.delete();
            if ($urandom_range(0, 4) != 0)
                add_expr($urandom_range(0, 3));
            else
                add_garbage();
            send_expr();
            sent += expr_buf.size();
        end
    endtask

    // Stall the output while short expressions keep arriving
    task automatic test_output_backpressure();
        -> hold_off_trig;
        repeat (30)
        begin
            expr_buf.delete();
            expr_buf.push_back(rand_digit());
            expr_buf.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            expr_buf.push_back(rand_digit());
            send_expr();
        end
    endtask

    // ---------------- sequence ----------------

    initial
    begin
        rst_n           = 1'b0;
        in_if.valid     = 1'b0;
        in_if.char_code = '0;
        in_if.last      = 1'b0;
        out_if.ready    = 1'b0;
        clear_state();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // sender idles rarely, receiver often
        src_idle_pct = 12;
        snk_idle_pct <= 84;
        test_directed_cases();
        test_stack_limits();
        test_random_expressions(330);

        // sender idles often, receiver rarely
        src_idle_pct = 84;
        snk_idle_pct <= 12;
        test_random_expressions(330);

        // no idling on either side
        src_idle_pct = 0;
        snk_idle_pct <= 0;
        test_output_backpressure();
        test_random_expressions(330);

        // drain outstanding results
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[add_sub_paren_expression_evaluator.f]
rtl/aspe_pkg.sv
rtl/aspe_if.sv
rtl/aspe_val_cell.sv
rtl/aspe_op_cell.sv
rtl/add_sub_paren_expression_evaluator.sv
verif/add_sub_paren_expression_evaluator_tb.sv
